// File: src/fbpa_pkg.sv
// ----------------------------------------------------------------------------
// fbpa_pkg: block pool allocator shared definitions
// command, status and register index codes, register reset values
// ----------------------------------------------------------------------------
package fbpa_pkg;

    typedef logic [1:0] t_cmd;
    typedef logic [1:0] t_status;
    typedef logic       t_cfg_idx;

    localparam t_cmd CMD_REQUEST = 2'd0;
    localparam t_cmd CMD_RELEASE = 2'd1;
    localparam t_cmd CMD_QUERY   = 2'd2;

    localparam t_status ST_OK        = 2'd0;
    localparam t_status ST_REFUSED   = 2'd1;
    localparam t_status ST_NOT_OWNER = 2'd2;

    localparam t_cfg_idx CFG_RESERVE_BLOCKS   = 1'b0;
    localparam t_cfg_idx CFG_RESERVE_ID_LIMIT = 1'b1;

    localparam int RESERVE_BLOCKS_RST   = 2;
    localparam int RESERVE_ID_LIMIT_RST = 10;

endpackage

// File: src/fbpa_ram.sv
// ----------------------------------------------------------------------------
// fbpa_ram: generic single-port-write ram
// one write port, one read port, registered read data
// ----------------------------------------------------------------------------
module fbpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: src/fbpa_clr.sv
// ----------------------------------------------------------------------------
// fbpa_clr: post-reset initialization sequencer
// walks every pool entry once, one per cycle, then goes quiet
// ----------------------------------------------------------------------------
module fbpa_clr #(
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    output logic                     o_busy,
    output logic [$clog2(DEPTH)-1:0] o_idx
);

    localparam int AW = $clog2(DEPTH);

    logic          r_busy;
    logic [AW-1:0] r_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
            r_idx  <= '0;
        end else if (r_busy) begin
            r_idx <= r_idx + AW'(1);
            if (r_idx == AW'(DEPTH - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_busy = r_busy;
    assign o_idx  = r_idx;

endmodule

// File: src/fixed_block_pool_allocator_core.sv
// ----------------------------------------------------------------------------
// fixed_block_pool_allocator_core: fixed-size block pool allocator
// lifo free stack with per-block owner tags, reserve rule and ownership check
// ----------------------------------------------------------------------------
// Takes one item per clock while o_stall is low and returns one result item for
// each. The item passes through the input register (execute stage) into the
// output register, where its result is presented; a stalled output side holds
// it in the input register. Each item reads the free stack and the owner table
// once (one ram read port each, registered read) and writes at most one entry
// of each; the next item's reads are issued from the updated stack pointer with
// write-to-read forwarding, so items can follow back to back. After reset a
// clearing pass fills the free stack with every block index and clears the
// owner table; o_stall stays high while it runs. Configuration writes are taken
// at any time and must only be issued while no item is in flight.
// ----------------------------------------------------------------------------
module fixed_block_pool_allocator_core
    import fbpa_pkg::*;
#(
    parameter int POOL_BLOCKS = 64,
    parameter int ID_BITS     = 4
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // item input channel
    input  logic                               i_valid,
    output logic                               o_stall,
    input  t_cmd                               i_cmd,
    input  logic [ID_BITS-1:0]                 i_requester_id,
    input  logic [$clog2(POOL_BLOCKS)-1:0]     i_block_index,
    // result channel
    output logic                               o_valid,
    input  logic                               i_stall,
    output t_status                            o_status,
    output logic [$clog2(POOL_BLOCKS)-1:0]     o_granted_block,
    output logic [$clog2(POOL_BLOCKS+1)-1:0]   o_free_count,
    // configuration write channel
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  t_cfg_idx                           i_cfg_index,
    input  logic [(($clog2(POOL_BLOCKS+1) > ID_BITS) ?
                   $clog2(POOL_BLOCKS+1) : ID_BITS)-1:0] i_cfg_data
);

    localparam int BW = $clog2(POOL_BLOCKS);      // block index width
    localparam int CW = $clog2(POOL_BLOCKS + 1);  // free count width
    localparam int OW = ID_BITS + 1;              // owner word: {in_use, tag}

    // configuration registers
    logic [CW-1:0]      r_res_blocks;
    logic [ID_BITS-1:0] r_res_limit;

    // stack pointer: number of free blocks
    logic [CW-1:0] r_top;
    logic [CW-1:0] n_top;
    logic [CW-1:0] top_m1;

    // input register (execute stage)
    logic               r_in_valid;
    t_cmd               r_cmd;
    logic [ID_BITS-1:0] r_id;
    logic [BW-1:0]      r_blk;

    // output register
    logic          r_out_valid;
    t_status       r_status;
    logic [BW-1:0] r_granted;
    logic [CW-1:0] r_free;

    // handshake
    logic accept;
    logic fire;

    // clearing pass
    logic          clr_busy;
    logic [BW-1:0] clr_idx;

    // ram ports
    logic          stk_we;
    logic [BW-1:0] stk_waddr;
    logic [BW-1:0] stk_wdata;
    logic [BW-1:0] stk_raddr;
    logic [BW-1:0] stk_rdata;
    logic          own_we;
    logic [BW-1:0] own_waddr;
    logic [OW-1:0] own_wdata;
    logic [BW-1:0] own_raddr;
    logic [OW-1:0] own_rdata;

    // forwarding of a write that hit the address read in the same cycle
    logic          r_stk_hit;
    logic [BW-1:0] r_stk_fwd;
    logic          r_own_hit;
    logic [OW-1:0] r_own_fwd;

    // execute stage results
    logic          x_stk_we;
    logic          x_own_we;
    logic [OW-1:0] x_own_wdata;
    logic [BW-1:0] x_own_waddr;
    t_status       x_status;
    logic [BW-1:0] x_granted;
    logic [CW-1:0] x_top;
    logic [BW-1:0] stk_top_blk;
    logic [OW-1:0] own_word;
    logic          pool_empty;
    logic          reserve_held;
    logic          release_bad;

    // ------------------------------------------------------------------------
    // clearing pass after reset
    // ------------------------------------------------------------------------
    fbpa_clr #(
        .DEPTH (POOL_BLOCKS)
    ) u_clr (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .o_busy  (clr_busy),
        .o_idx   (clr_idx)
    );

    // ------------------------------------------------------------------------
    // handshake: the input register drains into the output register whenever
    // the output register is empty or being taken this cycle
    // ------------------------------------------------------------------------
    assign fire    = r_in_valid && (!r_out_valid || !i_stall);
    assign o_stall = clr_busy || (r_in_valid && r_out_valid && i_stall);
    assign accept  = i_valid && !o_stall;

    assign o_cfg_ready = 1'b1;

    // ------------------------------------------------------------------------
    // execute: decide on the item in the input register
    // ------------------------------------------------------------------------
    // read data with same-cycle write forwarding
    assign stk_top_blk = r_stk_hit ? r_stk_fwd : stk_rdata;
    assign own_word    = r_own_hit ? r_own_fwd : own_rdata;

    // reserve rule: at or below the reserve, low ids are turned away
    assign pool_empty   = (r_top == '0);
    assign reserve_held = (r_top <= r_res_blocks) && (r_id < r_res_limit);

    // release is rejected for an index outside the pool, a free block, a
    // foreign owner, or a stack that is already full
    assign release_bad = ({1'b0, r_blk} >= (BW + 1)'(POOL_BLOCKS))
                      || !own_word[OW-1]
                      || (own_word[ID_BITS-1:0] != r_id)
                      || (r_top >= CW'(POOL_BLOCKS));

    always_comb begin
        x_stk_we    = 1'b0;
        x_own_we    = 1'b0;
        x_own_waddr = r_blk;
        x_own_wdata = '0;
        x_status    = ST_OK;
        x_granted   = '0;
        x_top       = r_top;
        unique case (r_cmd)
            CMD_REQUEST: begin
                if (pool_empty || reserve_held) begin
                    x_status = ST_REFUSED;
                end else begin
                    // pop the top block and tag it
                    x_top       = r_top - CW'(1);
                    x_granted   = stk_top_blk;
                    x_own_we    = 1'b1;
                    x_own_waddr = stk_top_blk;
                    x_own_wdata = {1'b1, r_id};
                end
            end
            CMD_RELEASE: begin
                if (release_bad) begin
                    x_status = ST_NOT_OWNER;
                end else begin
                    // push the block back and clear its tag
                    x_top    = r_top + CW'(1);
                    x_stk_we = 1'b1;
                    x_own_we = 1'b1;
                end
            end
            CMD_QUERY: begin
                x_status = ST_OK;
            end
            default: begin
                // unused code behaves as a query
                x_status = ST_OK;
            end
        endcase
    end

    assign n_top = fire ? x_top : r_top;

    // ------------------------------------------------------------------------
    // ram port muxing: clearing pass, otherwise the executing item
    // ------------------------------------------------------------------------
    assign stk_we    = clr_busy || (fire && x_stk_we);
    assign stk_waddr = clr_busy ? clr_idx : r_top[BW-1:0];
    assign stk_wdata = clr_busy ? clr_idx : r_blk;

    assign own_we    = clr_busy || (fire && x_own_we);
    assign own_waddr = clr_busy ? clr_idx : x_own_waddr;
    assign own_wdata = clr_busy ? '0 : x_own_wdata;

    // next item reads the entry just below the updated stack pointer
    assign top_m1    = n_top - CW'(1);
    assign stk_raddr = top_m1[BW-1:0];
    assign own_raddr = accept ? i_block_index : r_blk;

    fbpa_ram #(
        .WIDTH (BW),
        .DEPTH (POOL_BLOCKS)
    ) u_stack_ram (
        .i_clk   (i_clk),
        .i_we    (stk_we),
        .i_waddr (stk_waddr),
        .i_wdata (stk_wdata),
        .i_raddr (stk_raddr),
        .o_rdata (stk_rdata)
    );

    fbpa_ram #(
        .WIDTH (OW),
        .DEPTH (POOL_BLOCKS)
    ) u_owner_ram (
        .i_clk   (i_clk),
        .i_we    (own_we),
        .i_waddr (own_waddr),
        .i_wdata (own_wdata),
        .i_raddr (own_raddr),
        .o_rdata (own_rdata)
    );

    // forwarding registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stk_hit <= 1'b0;
            r_own_hit <= 1'b0;
        end else begin
            r_stk_hit <= stk_we && (stk_waddr == stk_raddr);
            r_own_hit <= own_we && (own_waddr == own_raddr);
        end
    end

    always_ff @(posedge i_clk) begin
        r_stk_fwd <= stk_wdata;
        r_own_fwd <= own_wdata;
    end

    // ------------------------------------------------------------------------
    // control registers
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top        <= CW'(POOL_BLOCKS);
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_res_blocks <= CW'(RESERVE_BLOCKS_RST);
            r_res_limit  <= ID_BITS'(RESERVE_ID_LIMIT_RST);
        end else begin
            r_top <= n_top;
            if (accept) begin
                r_in_valid <= 1'b1;
            end else if (fire) begin
                r_in_valid <= 1'b0;
            end
            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    CFG_RESERVE_BLOCKS:   r_res_blocks <= i_cfg_data[CW-1:0];
                    CFG_RESERVE_ID_LIMIT: r_res_limit  <= i_cfg_data[ID_BITS-1:0];
                    default: begin
                        r_res_blocks <= r_res_blocks;
                    end
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd <= i_cmd;
            r_id  <= i_requester_id;
            r_blk <= i_block_index;
        end
        if (fire) begin
            r_status  <= x_status;
            r_granted <= x_granted;
            r_free    <= x_top;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_status        = r_status;
    assign o_granted_block = r_granted;
    assign o_free_count    = r_free;

`ifndef SYNTHESIS
    // free count never exceeds the pool
    a_top_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_top <= CW'(POOL_BLOCKS))
        else $error("free count above pool size");

    // nothing enters the execute stage while the pool is being initialized
    a_clr_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        clr_busy |-> !r_in_valid)
        else $error("item in flight during clearing pass");

    // a granted request takes exactly one block off the stack
    a_grant_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && (r_cmd == CMD_REQUEST) && (x_status == ST_OK))
        |=> (r_top == $past(r_top) - CW'(1)))
        else $error("grant did not pop one block");

    // a refused or rejected item leaves the stack pointer alone
    a_reject_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && (x_status != ST_OK)) |=> (r_top == $past(r_top)))
        else $error("rejected item changed free count");

    // the reported free count matches the stack pointer right after execute
    a_free_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire |=> (o_free_count == r_top))
        else $error("reported free count differs from stack pointer");
`endif

endmodule
